>>> hw/rtl/vsp_pkg.sv
`default_nettype none
package vsp_pkg;

  localparam int unsigned VOLUME_SIDE_DEF = 32;
  localparam int unsigned LABEL_BITS_DEF  = 16;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_PAINT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_OUTSIDE  = 2'd1;
  localparam logic [1:0] STAT_READ_OUT = 2'd2;

  // scan half-width is at most 16, offsets stay within -16..16
  localparam int unsigned HALF_W  = 5;
  localparam int unsigned DELTA_W = 6;
  localparam int unsigned SQ_W    = 9;
  localparam int unsigned DIST_W  = 10;
  localparam int unsigned RSQ_W   = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PAINT,
    ST_READ
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        label;
    logic [7:0]         radius_q4;
  } req_t;

  typedef struct packed {
    logic [15:0] read_value;
    logic [1:0]  status;
  } res_t;

endpackage
`default_nettype wire

>>> hw/rtl/voxel_sphere_painter_top.sv
// Voxel sphere painter. A request is taken when start_i is high and busy_o is
// low; its single result appears on res_o for exactly one cycle with done_o
// high and cannot be held off, so the receiver must take it then. The label
// volume sits in one single-port synchronous RAM of 2^(3*clog2(VOLUME_SIDE))
// entries that is touched at most once per cycle, and that port sets the
// rate. A read registers its RAM word, then answers. A paint whose centre
// lies outside the extent answers without a scan; otherwise it scans N
// voxels, N being the voxel count of the cube of half-width floor(r)+1
// clipped to the extent (2197 for a radius from five up to below six well
// inside, 3375 for radius six). Clear sweeps every RAM entry, 32768 at the
// default size. The volume holds garbage after reset until the first clear.
// Configuration writes are always ready and must only be issued while busy_o
// is low and no result is pending.
`default_nettype none
module voxel_sphere_painter_top import vsp_pkg::*; #(
  parameter int unsigned VOLUME_SIDE = VOLUME_SIDE_DEF,
  parameter int unsigned LABEL_BITS  = LABEL_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire req_t                 req_i,
  output logic                      done_o,
  output res_t                      res_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned CW    = $clog2(VOLUME_SIDE);
  localparam int unsigned AW    = 3 * CW;
  localparam int unsigned DEPTH = 2 ** AW;
  localparam int unsigned SW    = $clog2(VOLUME_SIDE + 1);
  localparam int unsigned WW    = (SW > CFG_W) ? SW : CFG_W;
  localparam int unsigned EW    = ((CW > HALF_W) ? CW : HALF_W) + 2;

  // configuration
  logic [CFG_W-1:0] num_slices_q, num_rows_q, num_cols_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_slices_q <= CFG_RESET;
      num_rows_q   <= CFG_RESET;
      num_cols_q   <= CFG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_SLICES: num_slices_q <= cfg_data_i;
        CFG_ROWS:   num_rows_q   <= cfg_data_i;
        CFG_COLS:   num_cols_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // extent in use, saturated at the volume side
  logic [SW-1:0]    ext [3];
  logic [CFG_W-1:0] ext_reg [3];

  assign ext_reg[0] = num_cols_q;
  assign ext_reg[1] = num_rows_q;
  assign ext_reg[2] = num_slices_q;

  // request decode: inside check and clipped scan bounds per axis
  logic signed [15:0] pos_in [3];
  logic [2:0]         in_ax;
  logic               in_vol;
  logic [CW-1:0]      cen_in [3];
  logic [CW-1:0]      lo_in  [3];
  logic [CW-1:0]      hi_in  [3];
  logic signed [EW-1:0] lo_s [3];
  logic [EW-1:0]      hi_s   [3];
  logic [EW-1:0]      lim    [3];
  logic [HALF_W-1:0]  half_w;
  logic [15:0]        rsq_full;
  logic [RSQ_W-1:0]   rsq_in;
  logic [LABEL_BITS-1:0] label_in;

  assign pos_in[0] = req_i.pos_x;
  assign pos_in[1] = req_i.pos_y;
  assign pos_in[2] = req_i.pos_z;

  assign half_w   = {1'b0, req_i.radius_q4[7:4]} + HALF_W'(1);
  assign rsq_full = 16'(req_i.radius_q4) * 16'(req_i.radius_q4) + 16'd128;
  assign rsq_in   = rsq_full[15:8];
  assign label_in = LABEL_BITS'(32'(req_i.label));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ext[i] = (WW'(ext_reg[i]) > WW'(VOLUME_SIDE)) ? SW'(VOLUME_SIDE) : SW'(ext_reg[i]);
      in_ax[i] = !pos_in[i][15] && ({1'b0, pos_in[i][14:0]} < 16'(ext[i]));
      cen_in[i] = pos_in[i][CW-1:0];
      lo_s[i] = $signed(EW'(cen_in[i])) - $signed(EW'(half_w));
      hi_s[i] = EW'(cen_in[i]) + EW'(half_w);
      lim[i] = EW'(ext[i]) - EW'(1);
      lo_in[i] = lo_s[i][EW-1] ? '0 : lo_s[i][CW-1:0];
      hi_in[i] = (hi_s[i] > lim[i]) ? lim[i][CW-1:0] : hi_s[i][CW-1:0];
    end
  end

  assign in_vol = &in_ax;

  // item registers
  state_e              state_q, state_d;
  logic                done_q, done_d;
  res_t                res_q, res_d;
  logic [CW-1:0]       cen_q [3];
  logic [CW-1:0]       lo_q  [3];
  logic [CW-1:0]       hi_q  [3];
  logic [CW-1:0]       pos_q [3];
  logic [CW-1:0]       pos_d [3];
  logic [RSQ_W-1:0]    rsq_q;
  logic [LABEL_BITS-1:0] label_q;
  logic [AW-1:0]       clr_q, clr_d;
  logic                accept;

  // memory port
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_addr;
  logic [LABEL_BITS-1:0] mem_wdata;
  logic [LABEL_BITS-1:0] rd_data_q;
  logic [LABEL_BITS-1:0] vol_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vol_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= vol_mem[mem_addr];
    end
  end

  // distance of the current scan voxel
  logic signed [DELTA_W-1:0]   delta [3];
  logic signed [2*DELTA_W-1:0] prod  [3];
  logic [SQ_W-1:0]             sq    [3];
  logic [EW-1:0]               diff  [3];
  logic [DIST_W-1:0]           dist_sum;
  logic                        hit;
  logic [2:0]                  last;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i]  = EW'(pos_q[i]) - EW'(cen_q[i]);
      delta[i] = $signed(diff[i][DELTA_W-1:0]);
      prod[i]  = delta[i] * delta[i];
      sq[i]    = prod[i][SQ_W-1:0];
      last[i]  = (pos_q[i] == hi_q[i]);
    end
  end

  assign dist_sum = DIST_W'(sq[0]) + DIST_W'(sq[1]) + DIST_W'(sq[2]);
  assign hit      = (dist_sum <= DIST_W'(rsq_q));

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    res_d     = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {pos_q[2], pos_q[1], pos_q[0]};
    mem_wdata = label_q;
    clr_d     = clr_q;
    for (int i = 0; i < 3; i++) begin
      pos_d[i] = pos_q[i];
    end
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (req_i.operation)
            OP_CLEAR: begin
              state_d = ST_CLEAR;
              clr_d   = '0;
            end
            OP_PAINT: begin
              if (in_vol) begin
                state_d = ST_PAINT;
                for (int i = 0; i < 3; i++) begin
                  pos_d[i] = lo_in[i];
                end
              end else begin
                done_d       = 1'b1;
                res_d.status = STAT_OUTSIDE;
              end
            end
            OP_READ: begin
              if (in_vol) begin
                state_d  = ST_READ;
                mem_re   = 1'b1;
                mem_addr = {cen_in[2], cen_in[1], cen_in[0]};
              end else begin
                done_d       = 1'b1;
                res_d.status = STAT_READ_OUT;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end
      end
      ST_PAINT: begin
        mem_we = hit;
        // advance x fastest, then y, then z
        if (!last[0]) begin
          pos_d[0] = pos_q[0] + CW'(1);
        end else begin
          pos_d[0] = lo_q[0];
          if (!last[1]) begin
            pos_d[1] = pos_q[1] + CW'(1);
          end else begin
            pos_d[1] = lo_q[1];
            if (!last[2]) begin
              pos_d[2] = pos_q[2] + CW'(1);
            end else begin
              state_d = ST_IDLE;
              done_d  = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        state_d          = ST_IDLE;
        done_d           = 1'b1;
        res_d.read_value = 16'(32'(rd_data_q));
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    clr_q <= clr_d;
    for (int i = 0; i < 3; i++) begin
      pos_q[i] <= pos_d[i];
    end
    if (accept) begin
      rsq_q   <= rsq_in;
      label_q <= label_in;
      for (int i = 0; i < 3; i++) begin
        cen_q[i] <= cen_in[i];
        lo_q[i]  <= lo_in[i];
        hi_q[i]  <= hi_in[i];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while an operation is still running");

  a_write_scope: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_PAINT || state_q == ST_CLEAR))
    else $error("volume written outside paint or clear");

  a_scan_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAINT) |->
      (pos_q[0] >= lo_q[0]) && (pos_q[0] <= hi_q[0]) &&
      (pos_q[1] >= lo_q[1]) && (pos_q[1] <= hi_q[1]) &&
      (pos_q[2] >= lo_q[2]) && (pos_q[2] <= hi_q[2]))
    else $error("scan position left the clipped cube");

  a_read_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.operation == OP_READ && in_vol) |=> (state_q == ST_READ))
    else $error("inside read did not issue a RAM read");

  a_value_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.read_value != '0) |-> (res_o.status == STAT_OK))
    else $error("nonzero read value with error status");

endmodule
`default_nettype wire

>>> bench/voxel_sphere_painter_top_tb.sv
`timescale 1ns / 1ps
module voxel_sphere_painter_top_tb;
  import vsp_pkg::*;

  localparam int SIDE      = VOLUME_SIDE_DEF;
  localparam int VOX_TOTAL = SIDE * SIDE * SIDE;

  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned WATCHDOG_LIMIT = 150000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 8;
  localparam int unsigned PHASE_ITEMS    = 35;
  localparam int unsigned NUM_PHASES     = 7;

  typedef struct {
    req_t rq;
    bit   typed;
    res_t want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 start_i     = 1'b0;
  req_t                 req_i       = '0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 busy_o;
  logic                 done_o;
  logic                 cfg_ready_o;
  res_t                 res_o;

  voxel_sphere_painter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // shadow copy of the label volume and the extent registers
  logic [15:0]      label_store [VOX_TOTAL];
  logic [CFG_W-1:0] extent_z = CFG_RESET;
  logic [CFG_W-1:0] extent_y = CFG_RESET;
  logic [CFG_W-1:0] extent_x = CFG_RESET;

  res_t        expected_results [$];
  stim_row_t   directed_rows [$];
  res_t        oldest_result;
  int unsigned fail_count   = 0;
  int unsigned result_count = 0;
  int unsigned idle_cycles  = 0;
  int          last_cx      = 0;
  int          last_cy      = 0;
  int          last_cz      = 0;
  int          last_w       = 1;
  int          clears_left  = 3;
  bit          quick_phase  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int clamp_extent(logic [CFG_W-1:0] e);
    return (int'(e) > SIDE) ? SIDE : int'(e);
  endfunction

  function automatic int store_addr(int x, int y, int z);
    return (z * SIDE + y) * SIDE + x;
  endfunction

  // Apply one request to the shadow volume and return what the block must answer.
  function automatic res_t predict_outcome(req_t r);
    int   nx, ny, nz, px, py, pz, w, r2, dx, dy, dz, a;
    bit   in_vol;
    res_t res;
    nx = clamp_extent(extent_x);
    ny = clamp_extent(extent_y);
    nz = clamp_extent(extent_z);
    px = r.pos_x;
    py = r.pos_y;
    pz = r.pos_z;
    in_vol = px >= 0 && px < nx && py >= 0 && py < ny && pz >= 0 && pz < nz;
    res = '0;
    case (r.operation)
      OP_CLEAR: begin
        for (a = 0; a < VOX_TOTAL; a++) label_store[a] = '0;
      end
      OP_PAINT: begin
        if (!in_vol) begin
          res.status = STAT_OUTSIDE;
        end else begin
          w  = int'(r.radius_q4 >> 4) + 1;
          r2 = (int'(r.radius_q4) * int'(r.radius_q4) + 128) >> 8;
          for (dz = -w; dz <= w; dz++)
            for (dy = -w; dy <= w; dy++)
              for (dx = -w; dx <= w; dx++)
                if (pz + dz >= 0 && pz + dz < nz && py + dy >= 0 && py + dy < ny &&
                    px + dx >= 0 && px + dx < nx && dx * dx + dy * dy + dz * dz <= r2)
                  label_store[store_addr(px + dx, py + dy, pz + dz)] = r.label;
        end
      end
      OP_READ: begin
        if (!in_vol) res.status = STAT_READ_OUT;
        else res.read_value = label_store[store_addr(px, py, pz)];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void add_row(logic [1:0] op, int x, int y, int z, int lab, int rad,
                                  bit typed, logic [1:0] stat);
    stim_row_t row;
    row.rq.operation  = op;
    row.rq.pos_x      = 16'(x);
    row.rq.pos_y      = 16'(y);
    row.rq.pos_z      = 16'(z);
    row.rq.label      = 16'(lab);
    row.rq.radius_q4  = 8'(rad);
    row.typed         = typed;
    row.want.read_value = '0;
    row.want.status     = stat;
    directed_rows.push_back(row);
  endfunction

  function automatic int pick_coord(int ext);
    int               roll;
    logic signed [15:0] raw;
    roll = $urandom_range(0, 99);
    raw  = 16'($urandom);
    if (roll < 8) return raw;
    // land on and around the border of the extent
    if (roll < 22) return int'($urandom_range(0, ext + 3)) - 2;
    return (ext > 0) ? int'($urandom_range(0, ext - 1)) : 0;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   roll;
    roll        = $urandom_range(0, 99);
    r.pos_x     = 16'($urandom);
    r.pos_y     = 16'($urandom);
    r.pos_z     = 16'($urandom);
    r.label     = 16'($urandom);
    r.radius_q4 = ($urandom_range(0, 99) < 4) ? 8'($urandom) : 8'($urandom_range(0, 63));
    if (roll < 2 && clears_left > 0) begin
      r.operation = OP_CLEAR;
      clears_left--;
    end else if (roll < 7) begin
      r.operation = OP_UNUSED;
    end else if (roll < 52) begin
      r.operation = OP_PAINT;
      r.pos_x = 16'(pick_coord(clamp_extent(extent_x)));
      r.pos_y = 16'(pick_coord(clamp_extent(extent_y)));
      r.pos_z = 16'(pick_coord(clamp_extent(extent_z)));
      last_cx = r.pos_x;
      last_cy = r.pos_y;
      last_cz = r.pos_z;
      last_w  = int'(r.radius_q4 >> 4) + 1;
    end else begin
      r.operation = OP_READ;
      if ($urandom_range(0, 1) == 0) begin
        // probe the neighborhood of the latest sphere
        r.pos_x = 16'(last_cx + int'($urandom_range(0, 2 * last_w)) - last_w);
        r.pos_y = 16'(last_cy + int'($urandom_range(0, 2 * last_w)) - last_w);
        r.pos_z = 16'(last_cz + int'($urandom_range(0, 2 * last_w)) - last_w);
      end else begin
        r.pos_x = 16'(pick_coord(clamp_extent(extent_x)));
        r.pos_y = 16'(pick_coord(clamp_extent(extent_y)));
        r.pos_z = 16'(pick_coord(clamp_extent(extent_z)));
      end
    end
    return r;
  endfunction

  task automatic send_request(req_t r, bit typed, res_t want);
    int   gap;
    res_t outcome;
    gap = quick_phase ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    outcome = predict_outcome(r);
    expected_results.push_back(typed ? want : outcome);
  endtask

  // Hold off new requests until every pending result is back.
  task automatic wait_drained();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (HOLD_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_extents(logic [CFG_W-1:0] ez, logic [CFG_W-1:0] ey,
                               logic [CFG_W-1:0] ex);
    logic [CFG_W-1:0]     vals [3];
    logic [CFG_IDX_W-1:0] idx [3];
    int                   i;
    vals = '{ez, ey, ex};
    idx  = '{CFG_SLICES, CFG_ROWS, CFG_COLS};
    for (i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (idx[i])
        CFG_SLICES: extent_z = vals[i];
        CFG_ROWS:   extent_y = vals[i];
        CFG_COLS:   extent_x = vals[i];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      result_count++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("result %0d arrived with nothing pending: read_value %h status %0d",
                   result_count, res_o.read_value, res_o.status);
      end else begin
        oldest_result = expected_results.pop_front();
        if (res_o.read_value !== oldest_result.read_value ||
            res_o.status !== oldest_result.status) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result %0d mismatch: read_value exp %h got %h, status exp %0d got %0d",
                     result_count, oldest_result.read_value, res_o.read_value,
                     oldest_result.status, res_o.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned      ph;
    int unsigned      n;
    logic [CFG_W-1:0] ez, ey, ex;

    add_row(OP_CLEAR,     0,      0,      0,      0,       0,    1'b1, STAT_OK);
    add_row(OP_READ,      0,      0,      0,      0,       0,    1'b1, STAT_OK);
    add_row(OP_READ,      31,     31,     31,     0,       0,    1'b1, STAT_OK);
    add_row(OP_READ,      -1,     0,      0,      0,       0,    1'b1, STAT_READ_OUT);
    add_row(OP_READ,      32,     0,      0,      0,       0,    1'b1, STAT_READ_OUT);
    add_row(OP_READ,      0,      -32768, 0,      0,       0,    1'b1, STAT_READ_OUT);
    add_row(OP_READ,      0,      0,      32767,  0,       0,    1'b1, STAT_READ_OUT);
    add_row(OP_PAINT,     32767,  0,      0,      'hffff,  'h10, 1'b1, STAT_OUTSIDE);
    add_row(OP_PAINT,     0,      0,      -32768, 1,       'hff, 1'b1, STAT_OUTSIDE);
    // zero radius writes the centre voxel alone
    add_row(OP_PAINT,     5,      5,      5,      'hffff,  0,    1'b1, STAT_OK);
    add_row(OP_READ,      5,      5,      5,      0,       0,    1'b0, STAT_OK);
    add_row(OP_READ,      6,      5,      5,      0,       0,    1'b0, STAT_OK);
    add_row(OP_PAINT,     0,      0,      0,      'h1234,  'h18, 1'b0, STAT_OK);
    add_row(OP_READ,      1,      1,      0,      0,       0,    1'b0, STAT_OK);
    add_row(OP_READ,      1,      1,      1,      0,       0,    1'b0, STAT_OK);
    add_row(OP_PAINT,     31,     31,     31,     'ha5a5,  'h2f, 1'b0, STAT_OK);
    add_row(OP_READ,      30,     31,     31,     0,       0,    1'b0, STAT_OK);
    add_row(OP_UNUSED,    7,      7,      7,      'hbeef,  'h33, 1'b1, STAT_OK);
    add_row(OP_PAINT,     16,     16,     16,     'h5a5a,  'hff, 1'b0, STAT_OK);
    add_row(OP_READ,      0,      0,      0,      0,       0,    1'b0, STAT_OK);
    add_row(OP_READ,      16,     16,     16,     0,       0,    1'b0, STAT_OK);
    add_row(OP_PAINT,     10,     20,     30,     0,       'h60, 1'b0, STAT_OK);
    add_row(OP_READ,      10,     20,     30,     0,       0,    1'b0, STAT_OK);
    add_row(OP_UNUSED,    -1,     -1,     -1,     'hffff,  'hff, 1'b1, STAT_OK);
    add_row(OP_CLEAR,     0,      0,      0,      0,       0,    1'b1, STAT_OK);
    add_row(OP_READ,      16,     16,     16,     0,       0,    1'b1, STAT_OK);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[k])
      send_request(directed_rows[k].rq, directed_rows[k].typed, directed_rows[k].want);
    wait_drained();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin ez = 6'd1;  ey = 6'd1;  ex = 6'd1;  end
        1: begin ez = 6'd0;  ey = 6'd32; ex = 6'd32; end
        2: begin ez = 6'd63; ey = 6'd63; ex = 6'd63; end
        3: begin ez = 6'd32; ey = 6'd0;  ex = 6'd5;  end
        default: begin
          ez = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
          ey = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
          ex = ($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(1, 32));
        end
      endcase
      write_extents(ez, ey, ex);
      quick_phase = ($urandom_range(0, 2) == 0);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_request(random_request(), 1'b0, '0);
        if ($urandom_range(0, 24) == 0) wait_drained();
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
